[rtl/rse_pkg.sv]
// ----------------------------------------------------------------------------
// rse_pkg
// Shared widths, constants, register codes and the command and status
// structures that join the speed estimator's controller and datapath.
// ----------------------------------------------------------------------------
package rse_pkg;

    // Counts per turn is 2**ANGLE_BITS
    localparam int ANGLE_BITS = 12;

    // Field widths
    localparam int ANGLE_W    = 12;
    localparam int PERIOD_W   = 16;
    localparam int DISP_W     = 10;
    localparam int RPM_W      = 15;
    localparam int MS_W       = 16;

    // Port widths
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int PROD_W     = ANGLE_BITS + MS_W;
    localparam int DIVD_W     = RPM_W + DISP_W;
    localparam int DIVS_W     = PERIOD_W;
    localparam int STEP_W     = $clog2(DIVD_W);

    localparam logic [MS_W-1:0]       MS_PER_MIN = MS_W'(60000);
    localparam logic [ANGLE_BITS:0]   ANGLE_MOD  = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [RPM_W-1:0]      RPM_MAX    = RPM_W'(30000);

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(10);
    localparam logic [DISP_W-1:0]   DISP_MAX_RST = DISP_W'(100);
    localparam logic [RPM_W-1:0]    MEAS_MAX_RST = RPM_W'(2900);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD = 2'd0,
        CFG_DISPLAY_MAX   = 2'd1,
        CFG_MEASURED_MAX  = 2'd2
    } cfg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // latch input word
        logic restart_upd;  // store angle, clear filter
        logic mul_rpm;      // delta * 60000
        logic div_rpm_go;   // start rpm division
        logic rpm_cap;      // capture rpm quotient
        logic filt_upd;     // filter step and store angle
        logic mul_disp;     // filtered * display_max
        logic div_disp_go;  // start display division
        logic disp_cap;     // capture saturated display value
        logic out_load;     // load output register
        logic out_zero;     // output word is all zero
    } rse_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic restart;
        logic period_zero;
        logic div_done;
    } rse_status_t;

endpackage

[rtl/rotary_speed_estimator.sv]
// ----------------------------------------------------------------------------
// rotary_speed_estimator
// Angle-difference tachometer with a first-order filter and display scaling.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tdata: angle; s_tuser: restart
//  m_        out        m_tvalid/m_tready   m_tdata: display, filtered, rpm
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  A normal sample passes twice through the shared one-bit-per-cycle divider
//  (25 steps each) between accept and output word. Restart and zero-period
//  samples skip the multipliers and the divider and give an all-zero word.
//  One sample is in work at a time; a finished word waits in the output
//  register while the next sample is taken. A stalled word holds the
//  sequencer before it loads the following one.
//  aresetn is synchronous, active low; config returns to 10 / 100 / 2900.
//  Configuration writes are always ready.
// ----------------------------------------------------------------------------
module rotary_speed_estimator
    import rse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] angle
    input  logic                  s_tuser,   // [0] restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] speed_display,
                                             // [24:10] filtered_rpm,
                                             // [39:25] instant_rpm
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rse_cmd_t    cmd;
    rse_status_t status;

    assign cfg_ready = 1'b1;

    rse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rse_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/rse_divider.sv]
// ----------------------------------------------------------------------------
// rse_divider
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// only meaningful for a non-zero divisor; users keep a zero divisor out or
// override the result.
// ----------------------------------------------------------------------------
module rse_divider
    import rse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic [DIVD_W-1:0] quo_reg,   quo_next;
    logic [DIVS_W-1:0] rem_reg,   rem_next;
    logic [DIVS_W-1:0] dvs_reg,   dvs_next;
    logic [DIVS_W:0]   shifted;
    logic [DIVS_W:0]   trial;

    // One trial subtraction per cycle
    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = STEP_W'(DIVD_W - 1);
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            if (trial[DIVS_W]) begin
                rem_next = shifted[DIVS_W-1:0];
            end else begin
                rem_next = trial[DIVS_W-1:0];
            end
            quo_next = {quo_reg[DIVD_W-2:0], ~trial[DIVS_W]};
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/rse_datapath.sv]
// ----------------------------------------------------------------------------
// rse_datapath
// Configuration registers, angle and filter state, the two multipliers,
// the shared divider and the output register.
// ----------------------------------------------------------------------------
module rse_datapath
    import rse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rse_cmd_t              cmd,
    output rse_status_t           status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic [PERIOD_W-1:0]   period_reg;
    logic [DISP_W-1:0]     disp_max_reg;
    logic [RPM_W-1:0]      meas_max_reg;

    logic [ANGLE_BITS-1:0] angle_reg;
    logic                  restart_reg;
    logic [ANGLE_BITS-1:0] prev_reg;
    logic [RPM_W-1:0]      filt_reg;
    logic [PROD_W-1:0]     prod_rpm_reg;
    logic [DIVD_W-1:0]     prod_disp_reg;
    logic [RPM_W-1:0]      rpm_reg;
    logic [DISP_W-1:0]     disp_reg;
    logic [M_TDATA_W-1:0]  out_reg;

    logic [ANGLE_BITS-1:0] abs_diff;
    logic [ANGLE_BITS-1:0] delta;
    logic [ANGLE_BITS:0]   wrapped;
    logic [RPM_W+1:0]      filt_sum;
    logic                  div_start;
    logic [DIVD_W-1:0]     div_dividend;
    logic [DIVS_W-1:0]     div_divisor;
    logic                  div_done;
    logic [DIVD_W-1:0]     div_quotient;
    logic                  disp_sat;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RST;
            disp_max_reg <= DISP_MAX_RST;
            meas_max_reg <= MEAS_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD: period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_DISPLAY_MAX:   disp_max_reg <= cfg_data[DISP_W-1:0];
                CFG_MEASURED_MAX:  meas_max_reg <= cfg_data[RPM_W-1:0];
                default: ;
            endcase
        end
    end

    // Shortest-path angle difference magnitude; half a turn is not wrapped
    always_comb begin
        if (angle_reg >= prev_reg) begin
            abs_diff = angle_reg - prev_reg;
        end else begin
            abs_diff = prev_reg - angle_reg;
        end
        wrapped = ANGLE_MOD - {1'b0, abs_diff};
        if (abs_diff > ANGLE_HALF) begin
            delta = wrapped[ANGLE_BITS-1:0];
        end else begin
            delta = abs_diff;
        end
    end

    // filtered = (3 * filtered + rpm) / 4
    assign filt_sum = {1'b0, filt_reg, 1'b0} + (RPM_W + 2)'(filt_reg)
                    + (RPM_W + 2)'(rpm_reg);

    // Shared divider: rpm = (delta * 60000 >> ANGLE_BITS) / period,
    // display = filtered * display_max / measured_max
    assign div_start = cmd.div_rpm_go | cmd.div_disp_go;
    always_comb begin
        if (cmd.div_rpm_go) begin
            div_dividend = DIVD_W'(prod_rpm_reg[ANGLE_BITS+RPM_W-1:ANGLE_BITS]);
            div_divisor  = period_reg;
        end else begin
            div_dividend = prod_disp_reg;
            div_divisor  = DIVS_W'(meas_max_reg);
        end
    end

    rse_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign disp_sat = (meas_max_reg == '0) || (div_quotient > DIVD_W'(disp_max_reg));

    // State and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            filt_reg <= '0;
        end else if (cmd.restart_upd) begin
            prev_reg <= angle_reg;
            filt_reg <= '0;
        end else if (cmd.filt_upd) begin
            prev_reg <= angle_reg;
            filt_reg <= filt_sum[RPM_W+1:2];
        end
        if (cmd.load) begin
            angle_reg   <= ANGLE_BITS'(s_tdata[ANGLE_W-1:0]);
            restart_reg <= s_tuser;
        end
        if (cmd.mul_rpm) begin
            prod_rpm_reg <= PROD_W'(delta) * PROD_W'(MS_PER_MIN);
        end
        if (cmd.mul_disp) begin
            prod_disp_reg <= DIVD_W'(filt_reg) * DIVD_W'(disp_max_reg);
        end
        if (cmd.rpm_cap) begin
            rpm_reg <= div_quotient[RPM_W-1:0];
        end
        if (cmd.disp_cap) begin
            disp_reg <= disp_sat ? disp_max_reg : div_quotient[DISP_W-1:0];
        end
        if (cmd.out_load) begin
            out_reg <= cmd.out_zero ? '0 : {rpm_reg, filt_reg, disp_reg};
        end
    end

    assign status.restart     = restart_reg;
    assign status.period_zero = (period_reg == '0);
    assign status.div_done    = div_done;
    assign m_tdata            = out_reg;

endmodule

[rtl/rse_ctrl.sv]
// ----------------------------------------------------------------------------
// rse_ctrl
// Sequencer for one sample: decide, multiply, divide, filter, scale and
// hand the result word to the output register.
// ----------------------------------------------------------------------------
module rse_ctrl
    import rse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  rse_status_t status,
    output rse_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_RPM,
        ST_DIV_RPM,
        ST_WAIT_RPM,
        ST_FILTER,
        ST_MUL_DISP,
        ST_DIV_DISP,
        ST_WAIT_DISP,
        ST_OUT,
        ST_OUT_ZERO
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    // Output register can take a word when empty or draining
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.restart) begin
                    cmd.restart_upd = 1'b1;
                    state_next      = ST_OUT_ZERO;
                end else if (status.period_zero) begin
                    state_next = ST_OUT_ZERO;
                end else begin
                    state_next = ST_MUL_RPM;
                end
            end
            ST_MUL_RPM: begin
                cmd.mul_rpm = 1'b1;
                state_next  = ST_DIV_RPM;
            end
            ST_DIV_RPM: begin
                cmd.div_rpm_go = 1'b1;
                state_next     = ST_WAIT_RPM;
            end
            ST_WAIT_RPM: begin
                if (status.div_done) begin
                    cmd.rpm_cap = 1'b1;
                    state_next  = ST_FILTER;
                end
            end
            ST_FILTER: begin
                cmd.filt_upd = 1'b1;
                state_next   = ST_MUL_DISP;
            end
            ST_MUL_DISP: begin
                cmd.mul_disp = 1'b1;
                state_next   = ST_DIV_DISP;
            end
            ST_DIV_DISP: begin
                cmd.div_disp_go = 1'b1;
                state_next      = ST_WAIT_DISP;
            end
            ST_WAIT_DISP: begin
                if (status.div_done) begin
                    cmd.disp_cap = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_OUT_ZERO: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output word valid flag
    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[rtl/rse_checker.sv]
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks on the speed estimator, bound to the top level.
// ----------------------------------------------------------------------------
module rse_checker
    import rse_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // One sample at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after accept");

    // A stalled word stays offered
    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // A stalled word does not change
    a_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // Speeds stay within the full range of the sensor
    a_rpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:10] <= RPM_MAX) && (m_tdata[39:25] <= RPM_MAX))
        else $error("speed above range");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind rotary_speed_estimator rse_checker u_rse_checker (.*);

[tb/tb_rotary_speed_estimator.sv]
// ----------------------------------------------------------------------------
// tb_rotary_speed_estimator
// Self-checking bench for the angle-difference tachometer. A directed table
// covers the wrap cases, restart, a zero period and display saturation, and
// random phases follow under fresh register settings. Each accepted sample
// runs through a bench-side speed predictor. Every output word is checked
// field by field against the oldest prediction, with random stalls on both
// streams.
// ----------------------------------------------------------------------------
module tb_rotary_speed_estimator;
    import rse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int TURN         = 1 << ANGLE_BITS;
    localparam int HALF_TURN    = TURN / 2;
    localparam int PHASES       = 11;
    localparam int PHASE_WORDS  = 100;
    localparam int SETTLE_GAP   = 4;
    localparam int TAIL_CYCLES  = 70;
    localparam int IDLE_PCT     = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // output word, first field in the highest bits
    typedef struct packed {
        logic [RPM_W-1:0]  instant;
        logic [RPM_W-1:0]  filtered;
        logic [DISP_W-1:0] display;
    } speed_word_t;

    localparam speed_word_t ZERO_WORD = '0;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_index_t        reg_sel;
        logic [15:0]       value;    // angle or register data
        logic              restart;
        logic              typed;    // use the word below, not the predictor
        speed_word_t       want;
    } plan_row_t;

    localparam int PLAN_LEN = 30;

    // directed walk: wrap cases, restart, extremes, zero period
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd0,     1'b0, 1'b1, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd2048,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd0,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd4095,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd1,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd2049,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd1234,  1'b1, 1'b1, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd1234,  1'b0, 1'b1, ZERO_WORD},
        '{ROW_REG,    CFG_SAMPLE_PERIOD, 16'd1,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_MEASURED_MAX,  16'd1,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd3282,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd1234,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_DISPLAY_MAX,   16'd1023,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_MEASURED_MAX,  16'd0,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd3282,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_DISPLAY_MAX,   16'd0,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd1234,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_SAMPLE_PERIOD, 16'd0,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd100,   1'b0, 1'b1, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd200,   1'b1, 1'b1, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd4000,  1'b0, 1'b1, ZERO_WORD},
        '{ROW_REG,    CFG_SAMPLE_PERIOD, 16'd65535, 1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_DISPLAY_MAX,   16'd1000,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_MEASURED_MAX,  16'd32767, 1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd2248,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_SAMPLE_PERIOD, 16'd2,     1'b0, 1'b0, ZERO_WORD},
        '{ROW_REG,    CFG_MEASURED_MAX,  16'd30000, 1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd200,   1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd2248,  1'b0, 1'b0, ZERO_WORD},
        '{ROW_SAMPLE, CFG_SAMPLE_PERIOD, 16'd4095,  1'b0, 1'b0, ZERO_WORD}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;     // [11:0] angle
    logic                  s_tuser   = 1'b0;   // [0] restart
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // [9:0] display, [24:10] filtered,
                                               // [39:25] instant
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state and register shadow
    logic [ANGLE_BITS-1:0] last_angle   = '0;
    logic [RPM_W-1:0]      smooth_rpm   = '0;
    logic [PERIOD_W-1:0]   period_ms    = PERIOD_RST;
    logic [DISP_W-1:0]     disp_full    = DISP_MAX_RST;
    logic [RPM_W-1:0]      rpm_full     = MEAS_MAX_RST;

    speed_word_t           pending_words [$];
    int                    mismatches = 0;
    int                    cycles     = 0;
    bit                    calm       = 1'b0;
    bit                    cfg_open   = 1'b0;
    logic [ANGLE_BITS-1:0] shaft_pos  = '0;

    rotary_speed_estimator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_rotary_speed_estimator: errors");
            $finish;
        end
    end

    // One sample through the tachometer: shortest-path delta, rpm, filter,
    // display scaling. Restart and a zero period give an all-zero word.
    function automatic speed_word_t track_speed(input logic [ANGLE_BITS-1:0] angle,
                                                input logic restart);
        speed_word_t       w;
        int                delta;
        longint unsigned   rpm;
        longint unsigned   scaled;
        w = '0;
        if (restart) begin
            last_angle = angle;
            smooth_rpm = '0;
            return w;
        end
        if (period_ms == '0)
            return w;
        delta = int'(angle) - int'(last_angle);
        if (delta > HALF_TURN)
            delta -= TURN;
        else if (delta < -HALF_TURN)
            delta += TURN;
        if (delta < 0)
            delta = -delta;
        rpm = (64'(delta) * 64'(MS_PER_MIN)) / (64'(TURN) * 64'(period_ms));
        w.instant  = rpm[RPM_W-1:0];
        smooth_rpm = RPM_W'((64'(smooth_rpm) * 3 + 64'(w.instant)) / 4);
        last_angle = angle;
        if (rpm_full == '0) begin
            scaled = 64'(disp_full);
        end else begin
            scaled = 64'(smooth_rpm) * 64'(disp_full) / 64'(rpm_full);
            if (scaled > 64'(disp_full))
                scaled = 64'(disp_full);
        end
        w.display  = scaled[DISP_W-1:0];
        w.filtered = smooth_rpm;
        return w;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // output side: random stalls, compare each word with the oldest prediction
    always @(posedge aclk) begin
        speed_word_t got;
        speed_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = speed_word_t'(m_tdata);
            if (pending_words.size() == 0) begin
                note_mismatch("unexpected word", 0, int'(got));
            end else begin
                want = pending_words.pop_front();
                if (got.display != want.display)
                    note_mismatch("speed_display", want.display, got.display);
                if (got.filtered != want.filtered)
                    note_mismatch("filtered_rpm", want.filtered, got.filtered);
                if (got.instant != want.instant)
                    note_mismatch("instant_rpm", want.instant, got.instant);
            end
        end
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // drain the block, then let it rest before a register write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    // valid is left high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (sel)
            CFG_SAMPLE_PERIOD: period_ms = value;
            CFG_DISPLAY_MAX:   disp_full = value[DISP_W-1:0];
            CFG_MEASURED_MAX:  rpm_full  = value[RPM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [ANGLE_BITS-1:0] angle, input logic restart,
                               input logic typed, input speed_word_t want);
        speed_word_t w;
        if (cfg_open) begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(angle);
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        w = track_speed(angle, restart);
        pending_words.push_back(typed ? want : w);
        shaft_pos = angle;
    endtask

    // stimulus
    initial begin
        int          roll;
        int          speed_step;
        logic [15:0] value;
        logic [ANGLE_BITS-1:0] angle;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (!cfg_open)
                    settle();
                cfg_open = 1'b1;
                write_reg(plan[i].reg_sel, plan[i].value);
            end else begin
                send_sample(plan[i].value[ANGLE_BITS-1:0], plan[i].restart,
                            plan[i].typed, plan[i].want);
            end
        end

        // random phases under fresh settings
        for (int p = 0; p < PHASES; p++) begin
            calm = (p == 4) || (p == 5);
            settle();
            cfg_open = 1'b1;

            roll = $urandom_range(99);
            if (roll < 55)      value = 16'($urandom_range(1, 12));
            else if (roll < 70) value = 16'd1;
            else if (roll < 80) value = 16'd0;
            else if (roll < 90) value = 16'd65535;
            else                value = 16'($urandom);
            write_reg(CFG_SAMPLE_PERIOD, value);

            roll = $urandom_range(99);
            if (roll < 10)      value = 16'd0;
            else if (roll < 20) value = 16'd1023;
            else if (roll < 30) value = 16'd1000;
            else if (roll < 40) value = 16'($urandom);
            else                value = 16'($urandom_range(1, 1000));
            write_reg(CFG_DISPLAY_MAX, value);

            roll = $urandom_range(99);
            if (roll < 10)      value = 16'd0;
            else if (roll < 20) value = 16'd32767;
            else if (roll < 30) value = 16'd1;
            else if (roll < 40) value = 16'($urandom);
            else                value = 16'($urandom_range(1, 30000));
            write_reg(CFG_MEASURED_MAX, value);

            // the spare index must not disturb anything
            if ($urandom_range(2) == 0)
                write_reg(CFG_SPARE, 16'($urandom));

            // a steady shaft speed per phase, with jitter and odd jumps
            roll = $urandom_range(99);
            if (roll < 30)      speed_step = $urandom_range(0, 40) - 20;
            else if (roll < 45) speed_step = ($urandom_range(1) != 0) ? HALF_TURN : -HALF_TURN;
            else                speed_step = $urandom_range(0, TURN) - HALF_TURN;

            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(99);
                if (roll < 4) begin
                    send_sample(ANGLE_BITS'($urandom), 1'b1, 1'b0, ZERO_WORD);
                end else begin
                    if (roll < 12)
                        angle = ANGLE_BITS'($urandom);
                    else if (roll < 18)
                        angle = shaft_pos + ANGLE_BITS'(HALF_TURN);
                    else
                        angle = shaft_pos + ANGLE_BITS'(speed_step)
                              + ANGLE_BITS'($urandom_range(0, 16) - 8);
                    send_sample(angle, 1'b0, 1'b0, ZERO_WORD);
                end
            end
        end

        // drain and verdict
        calm = 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("tb_rotary_speed_estimator: clean");
        else
            $display("tb_rotary_speed_estimator: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/rse_pkg.sv
rtl/rse_divider.sv
rtl/rse_datapath.sv
rtl/rse_ctrl.sv
rtl/rotary_speed_estimator.sv
rtl/rse_checker.sv
tb/tb_rotary_speed_estimator.sv
